// ===== rtl/core/b64lh_pkg.sv =====
// shared types, constants and the sextet-to-ascii function for the base64
// encoder with length header; no dependencies
package b64lh_pkg;

    // default depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_PAD = 8'h3D;   // '='
    localparam logic [7:0] CHAR_NL  = 8'h0A;   // newline

    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // what the group part of a job holds
    typedef enum logic [1:0] {
        GRP_NONE,   // no group
        GRP_FULL,   // three bytes, four characters
        GRP_ONE,    // one byte, two characters and two pads
        GRP_TWO     // two bytes, three characters and one pad
    } t_grp;

    // one unit of work for the back: everything a single transaction emits
    typedef struct packed {
        logic        hdr;         // first header group present
        logic [23:0] hdr_triple;
        t_grp        grp;
        logic [23:0] grp_triple;
        logic        nl;          // trailing newline
    } t_job;

    // back sequencer phases
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HDR,
        PH_GRP,
        PH_NL
    } t_phase;

    // standard base64 alphabet
    function automatic logic [7:0] f_b64_char(input logic [5:0] s);
        logic [7:0] v;
        v = {2'b00, s};
        if (s < 6'd26) begin
            f_b64_char = 8'h41 + v;
        end else if (s < 6'd52) begin
            f_b64_char = 8'h61 + v - 8'd26;
        end else if (s < 6'd62) begin
            f_b64_char = 8'h30 + v - 8'd52;
        end else if (s == 6'd62) begin
            f_b64_char = 8'h2B;
        end else begin
            f_b64_char = 8'h2F;
        end
    endfunction

    // first phase of a job; every queued job emits something
    function automatic t_phase f_first_phase(input t_job j);
        if (j.hdr) begin
            f_first_phase = PH_HDR;
        end else if (j.grp != GRP_NONE) begin
            f_first_phase = PH_GRP;
        end else begin
            f_first_phase = PH_NL;
        end
    endfunction

endpackage

// ===== rtl/core/b64lh_front.sv =====
// front part: accepts transactions, keeps the group state and the length
// register, and turns each transaction with output into a job; uses b64lh_pkg
module b64lh_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_command,
    input  logic [7:0]          i_data_byte,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_payload_bytes,
    input  logic                i_q_full,
    output logic                o_q_push,
    output b64lh_pkg::t_job     o_q_job
);

    logic [31:0] r_payload;
    logic [1:0]  r_fill, n_fill;
    logic [15:0] r_pending, n_pending;
    logic        r_hdr_sent, n_hdr_sent;
    logic        accept;
    b64lh_pkg::t_job job;
    logic        has_out;

    assign o_ready     = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;

    // length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload <= '0;
        end else if (i_cfg_valid) begin
            r_payload <= i_cfg_payload_bytes;
        end
    end

    // classify the transaction and build its job
    always_comb begin
        job            = '0;
        job.grp        = b64lh_pkg::GRP_NONE;
        has_out        = 1'b0;
        n_fill         = r_fill;
        n_pending      = r_pending;
        n_hdr_sent     = r_hdr_sent;
        job.hdr_triple = {r_payload[7:0], r_payload[15:8], r_payload[23:16]};
        if (i_command == b64lh_pkg::CMD_BYTE) begin
            if (!r_hdr_sent) begin
                // header bytes 0..2 form a group, byte 3 and data stay held
                job.hdr    = 1'b1;
                has_out    = 1'b1;
                n_pending  = {r_payload[31:24], i_data_byte};
                n_fill     = 2'd2;
                n_hdr_sent = 1'b1;
            end else if (r_fill == 2'd2) begin
                job.grp        = b64lh_pkg::GRP_FULL;
                job.grp_triple = {r_pending, i_data_byte};
                has_out        = 1'b1;
                n_pending      = '0;
                n_fill         = 2'd0;
            end else begin
                n_pending = {r_pending[7:0], i_data_byte};
                n_fill    = r_fill + 2'd1;
            end
        end else begin
            // finish: flush partial group, newline, rearm
            has_out = 1'b1;
            job.nl  = 1'b1;
            if (!r_hdr_sent) begin
                job.hdr        = 1'b1;
                job.grp        = b64lh_pkg::GRP_ONE;
                job.grp_triple = {r_payload[31:24], 16'h0000};
            end else if (r_fill == 2'd1) begin
                job.grp        = b64lh_pkg::GRP_ONE;
                job.grp_triple = {r_pending[7:0], 16'h0000};
            end else if (r_fill == 2'd2) begin
                job.grp        = b64lh_pkg::GRP_TWO;
                job.grp_triple = {r_pending, 8'h00};
            end
            n_pending  = '0;
            n_fill     = 2'd0;
            n_hdr_sent = 1'b0;
        end
    end

    assign o_q_push = accept && has_out;
    assign o_q_job  = job;

    // group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_pending  <= '0;
            r_hdr_sent <= 1'b0;
        end else if (accept) begin
            r_fill     <= n_fill;
            r_pending  <= n_pending;
            r_hdr_sent <= n_hdr_sent;
        end
    end

endmodule

// ===== rtl/core/b64lh_queue.sv =====
// small job queue between front and back; register array with read and
// write pointers and a fill count; uses b64lh_pkg
module b64lh_queue #(
    parameter int DEPTH = b64lh_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64lh_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output b64lh_pkg::t_job o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64lh_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("queue count out of range");

endmodule

// ===== rtl/core/b64lh_back.sv =====
// back part: walks each job character by character into an output register
// with valid and ready; uses b64lh_pkg
module b64lh_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  b64lh_pkg::t_job i_q_job,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_char,
    output logic            o_last
);

    b64lh_pkg::t_phase r_phase, n_phase;
    logic [1:0]        r_idx, n_idx;
    b64lh_pkg::t_job   r_job;
    logic              r_out_valid;
    logic [7:0]        r_out_char;
    logic              r_out_last;
    logic              slot_free;
    logic [7:0]        cur_char;
    logic              cur_last;
    logic [23:0]       cur_triple;
    logic [5:0]        sextet;
    logic              load;

    function automatic logic [7:0] b64_pkg_char(input logic [5:0] s);
        b64_pkg_char = b64lh_pkg::f_b64_char(s);
    endfunction

    assign slot_free = !r_out_valid || i_ready;

    // current character and end-of-job flag
    always_comb begin
        cur_triple = (r_phase == b64lh_pkg::PH_HDR) ? r_job.hdr_triple : r_job.grp_triple;
        unique case (r_idx)
            2'd0:    sextet = cur_triple[23:18];
            2'd1:    sextet = cur_triple[17:12];
            2'd2:    sextet = cur_triple[11:6];
            default: sextet = cur_triple[5:0];
        endcase
        cur_char = b64_pkg_char(sextet);
        cur_last = 1'b0;
        unique case (r_phase)
            b64lh_pkg::PH_HDR: begin
                cur_last = (r_idx == 2'd3) && (r_job.grp == b64lh_pkg::GRP_NONE) && !r_job.nl;
            end
            b64lh_pkg::PH_GRP: begin
                if ((r_job.grp == b64lh_pkg::GRP_ONE) && (r_idx >= 2'd2)) begin
                    cur_char = b64lh_pkg::CHAR_PAD;
                end else if ((r_job.grp == b64lh_pkg::GRP_TWO) && (r_idx == 2'd3)) begin
                    cur_char = b64lh_pkg::CHAR_PAD;
                end
                cur_last = (r_idx == 2'd3) && !r_job.nl;
            end
            b64lh_pkg::PH_NL: begin
                cur_char = b64lh_pkg::CHAR_NL;
                cur_last = 1'b1;
            end
            default: begin
                cur_last = 1'b0;
            end
        endcase
        // take the next job when idle or when the current one ends
        load    = i_q_valid && ((r_phase == b64lh_pkg::PH_IDLE) || (slot_free && cur_last));
        o_q_pop = load;
    end

    // next phase and character index
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        if (load) begin
            n_phase = b64lh_pkg::f_first_phase(i_q_job);
            n_idx   = 2'd0;
        end else if ((r_phase != b64lh_pkg::PH_IDLE) && slot_free) begin
            priority if (cur_last) begin
                n_phase = b64lh_pkg::PH_IDLE;
                n_idx   = 2'd0;
            end else if ((r_phase == b64lh_pkg::PH_HDR) && (r_idx == 2'd3)) begin
                n_phase = (r_job.grp != b64lh_pkg::GRP_NONE) ? b64lh_pkg::PH_GRP
                                                              : b64lh_pkg::PH_NL;
                n_idx   = 2'd0;
            end else if ((r_phase == b64lh_pkg::PH_GRP) && (r_idx == 2'd3)) begin
                n_phase = b64lh_pkg::PH_NL;
                n_idx   = 2'd0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64lh_pkg::PH_IDLE;
            r_idx   <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    // held job
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_q_job;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= (r_phase != b64lh_pkg::PH_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            r_out_char <= cur_char;
            r_out_last <= cur_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_char = r_out_char;
    assign o_last     = r_out_last;

    a_hdr_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == b64lh_pkg::PH_HDR) |-> r_job.hdr)
        else $error("header phase without header group");
    a_grp_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == b64lh_pkg::PH_GRP) |-> (r_job.grp != b64lh_pkg::GRP_NONE))
        else $error("group phase without group");
    a_nl_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_char == b64lh_pkg::CHAR_NL)) |-> r_out_last)
        else $error("newline not flagged last");
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_phase != b64lh_pkg::PH_IDLE))
        else $error("job loaded but sequencer idle");

endmodule

// ===== rtl/core/base64_encoder_length_header.sv =====
// Base64 encoder with a 32-bit little-endian length header.
// Input channel (i_valid/o_ready): one transaction carries i_command and
// i_data_byte; command 0 is a payload byte, command 1 finishes the stream.
// Output channel (o_valid/i_ready): one base64 character, '=' pad or newline
// per transaction; o_last marks the final character caused by an input.
// Config channel (i_cfg_valid/o_cfg_ready, always ready) loads the byte
// count that goes into the header; write it only while the block is idle.
// The header is encoded ahead of the first byte of each stream, or at finish
// for an empty stream. After a finish the block rearms for a new stream.
// The first character of an input passes the job queue and the back's
// sequencer state before it leaves the output register. The back emits one
// character per cycle while the receiver is ready, so throughput is set by
// the output: four characters per three bytes, nine for an empty stream,
// and none while the queue is dry; inputs that make no output push no job.
// When the receiver stalls, characters wait in the output register and the
// job queue (QUEUE_DEPTH jobs) keeps taking inputs until it fills.
// Reset is synchronous, active low; it clears the stream state, the queue,
// the output valid and the length register to zero.
// Uses b64lh_pkg, b64lh_front, b64lh_queue and b64lh_back.
module base64_encoder_length_header #(
    parameter int QUEUE_DEPTH = b64lh_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_char,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_payload_bytes
);

    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    b64lh_pkg::t_job push_job;
    b64lh_pkg::t_job pop_job;

    // accept and classify
    b64lh_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_command           (i_command),
        .i_data_byte         (i_data_byte),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_payload_bytes (i_cfg_payload_bytes),
        .i_q_full            (q_full),
        .o_q_push            (q_push),
        .o_q_job             (push_job)
    );

    // job queue
    b64lh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    // character sequencer and output register
    b64lh_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_job    (pop_job),
        .o_q_pop    (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

endmodule
